### hdl/tlbl_pkg.sv
// shared constants and types for the lru translation buffer
package tlbl_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int VPAGE_BITS = 20;
  localparam int PPAGE_BITS = 20;
  localparam int STAMP_BITS = 32;
  localparam int FUNC_BITS  = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_FILL   = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef struct packed {
    logic [VPAGE_BITS-1:0] virt;
    logic [PPAGE_BITS-1:0] phys;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

### hdl/tlbl_ram.sv
// generic simple dual port ram with registered read
module tlbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/tlb_with_lru_replacement.sv
// top level of the fully associative translation buffer with lru replacement
//
// Fully associative translation buffer. Each input beat carries one operation
// (lookup, fill or flush-all) and gives exactly one result beat. Page pairs and
// use stamps live in one entry ram with a registered read; valid bits sit in
// flops. A lookup or a fill walks the ram one entry per cycle: a lookup stops
// at the first hit or after the last entry, a fill always runs the full victim
// scan and then writes the chosen entry, and a flush or the unused code goes
// straight to the response state. The ram scan sets the rate; one operation is
// in flight at a time, and the next beat is taken while a result still waits
// at the output register. There is no process identifier.
module tlb_with_lru_replacement (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tlbl_pkg::FUNC_BITS-1:0]  in_func,
  input  logic [tlbl_pkg::VPAGE_BITS-1:0] in_virt_page,
  input  logic [tlbl_pkg::PPAGE_BITS-1:0] in_phys_page,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [tlbl_pkg::PPAGE_BITS-1:0] out_result_page
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } state_t;

  localparam logic [tlbl_pkg::IDX_BITS-1:0] LAST_IDX = tlbl_pkg::IDX_BITS'(tlbl_pkg::ENTRIES - 1);
  localparam logic [tlbl_pkg::IDX_BITS:0]   END_CNT  = (tlbl_pkg::IDX_BITS + 1)'(tlbl_pkg::ENTRIES);

  state_t                            state_r, state_nxt;
  tlbl_pkg::func_t                   op_r, op_nxt;
  logic [tlbl_pkg::VPAGE_BITS-1:0]   vpage_r, vpage_nxt;
  logic [tlbl_pkg::PPAGE_BITS-1:0]   ppage_r, ppage_nxt;
  logic [tlbl_pkg::IDX_BITS:0]       rd_idx_r, rd_idx_nxt;
  logic                              dv_r, dv_nxt;
  logic [tlbl_pkg::IDX_BITS-1:0]     di_r, di_nxt;
  logic [tlbl_pkg::IDX_BITS-1:0]     cand_r, cand_nxt;
  logic [tlbl_pkg::STAMP_BITS-1:0]   cand_stamp_r, cand_stamp_nxt;
  logic [tlbl_pkg::STAMP_BITS-1:0]   ctr_r, ctr_nxt;
  logic [tlbl_pkg::ENTRIES-1:0]      valid_r, valid_nxt;
  logic [tlbl_pkg::ENTRIES-1:0]      written_r, written_nxt;
  logic                              res_hit_r, res_hit_nxt;
  logic [tlbl_pkg::PPAGE_BITS-1:0]   res_page_r, res_page_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_hit_r, out_hit_nxt;
  logic [tlbl_pkg::PPAGE_BITS-1:0]   out_page_r, out_page_nxt;

  logic                              ram_wr_en;
  logic [tlbl_pkg::IDX_BITS-1:0]     ram_wr_addr;
  tlbl_pkg::entry_t                  ram_wr_data;
  logic [tlbl_pkg::ENTRY_BITS-1:0]   ram_rd_data;
  tlbl_pkg::entry_t                  cur;
  logic                              cur_valid;
  logic                              in_acc;
  logic                              out_free;
  logic [tlbl_pkg::STAMP_BITS-1:0]   ctr_inc;

  tlbl_ram #(
    .WIDTH (tlbl_pkg::ENTRY_BITS),
    .DEPTH (tlbl_pkg::ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (rd_idx_r[tlbl_pkg::IDX_BITS-1:0]),
    .rd_data (ram_rd_data)
  );

  // entries never written read as the reset value
  assign cur       = written_r[di_r] ? tlbl_pkg::entry_t'(ram_rd_data) : '0;
  assign cur_valid = valid_r[di_r];
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign ctr_inc   = ctr_r + tlbl_pkg::STAMP_BITS'(1);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    vpage_nxt      = vpage_r;
    ppage_nxt      = ppage_r;
    rd_idx_nxt     = rd_idx_r;
    dv_nxt         = dv_r;
    di_nxt         = di_r;
    cand_nxt       = cand_r;
    cand_stamp_nxt = cand_stamp_r;
    ctr_nxt        = ctr_r;
    valid_nxt      = valid_r;
    written_nxt    = written_r;
    res_hit_nxt    = res_hit_r;
    res_page_nxt   = res_page_r;
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_page_nxt   = out_page_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = di_r;
    ram_wr_data    = '{virt: cur.virt, phys: cur.phys, stamp: ctr_inc};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = tlbl_pkg::func_t'(in_func);
          vpage_nxt    = in_virt_page;
          ppage_nxt    = in_phys_page;
          rd_idx_nxt   = '0;
          dv_nxt       = 1'b0;
          res_hit_nxt  = 1'b0;
          res_page_nxt = '0;
          case (tlbl_pkg::func_t'(in_func))
            tlbl_pkg::FUNC_LOOKUP, tlbl_pkg::FUNC_FILL: begin
              state_nxt = S_SCAN;
            end
            tlbl_pkg::FUNC_FLUSH: begin
              valid_nxt = '0;
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_idx_r != END_CNT) begin
          dv_nxt     = 1'b1;
          di_nxt     = rd_idx_r[tlbl_pkg::IDX_BITS-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r) begin
          if (op_r == tlbl_pkg::FUNC_LOOKUP) begin
            if (cur_valid && cur.virt == vpage_r) begin
              ram_wr_en    = 1'b1;
              ctr_nxt      = ctr_inc;
              res_hit_nxt  = 1'b1;
              res_page_nxt = cur.phys;
              dv_nxt       = 1'b0;
              state_nxt    = S_RESP;
            end else if (di_r == LAST_IDX) begin
              dv_nxt    = 1'b0;
              state_nxt = S_RESP;
            end
          end else begin
            if (di_r == '0) begin
              cand_nxt       = '0;
              cand_stamp_nxt = cur.stamp;
            end else if (!cur_valid || cur.stamp < cand_stamp_r) begin
              cand_nxt       = di_r;
              cand_stamp_nxt = cur.stamp;
            end
            if (di_r == LAST_IDX) begin
              dv_nxt    = 1'b0;
              state_nxt = S_UPDATE;
            end
          end
        end
      end

      S_UPDATE: begin
        ram_wr_en           = 1'b1;
        ram_wr_addr         = cand_r;
        ram_wr_data         = '{virt: vpage_r, phys: ppage_r, stamp: ctr_inc};
        valid_nxt[cand_r]   = 1'b1;
        written_nxt[cand_r] = 1'b1;
        ctr_nxt             = ctr_inc;
        state_nxt           = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_page_nxt  = res_page_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dv_r        <= 1'b0;
      ctr_r       <= '0;
      valid_r     <= '0;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      ctr_r       <= ctr_nxt;
      valid_r     <= valid_nxt;
      written_r   <= written_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    vpage_r      <= vpage_nxt;
    ppage_r      <= ppage_nxt;
    rd_idx_r     <= rd_idx_nxt;
    di_r         <= di_nxt;
    cand_r       <= cand_nxt;
    cand_stamp_r <= cand_stamp_nxt;
    res_hit_r    <= res_hit_nxt;
    res_page_r   <= res_page_nxt;
    out_hit_r    <= out_hit_nxt;
    out_page_r   <= out_page_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_result_page = out_page_r;

endmodule
